// ----- src/header_length_sum_frame_receiver_assert.svh -----
// Assertion macros used by the frame receiver RTL.
`ifndef HEADER_LENGTH_SUM_FRAME_RECEIVER_ASSERT_SVH
`define HEADER_LENGTH_SUM_FRAME_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HLSFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HLSFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hlsfr_pkg.sv -----
// Types and constants of the header/length/sum frame receiver.
`timescale 1ns / 1ps

package hlsfr_pkg;

    // Default frame store depth.
    localparam int BUF_DEPTH = 256;

    // Write position width; the position never passes 255.
    localparam int POS_W = 8;

    // Configuration register indexes.
    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    // Configuration reset values.
    localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
    localparam logic [7:0] HEADER_SECOND_RST = 8'd85;

    // Input action codes.
    localparam logic [1:0] ACT_PUSH    = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_STORED   = 3'd1;
    localparam logic [2:0] ST_GOOD     = 3'd2;
    localparam logic [2:0] ST_BAD      = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;
    localparam logic [2:0] ST_RELEASED = 3'd6;

    // One input transaction.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_data;
        logic [7:0]  held_length;
        logic [31:0] error_total;
    } out_item_t;

endpackage

// ----- src/hlsfr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module hlsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/header_length_sum_frame_receiver.sv -----
// Top level of the byte-stream frame receiver with header, length and 16-bit sum.
`timescale 1ns / 1ps

// Channel   | Ports                        | Contents
// ----------+------------------------------+------------------------------------------
// input     | s_valid, s_ready, s_item     | action, data_byte, read_index
// result    | m_valid, m_ready, m_item     | status, read_data, held_length, error_total
// config    | cfg_wr_en/_index/_data       | header_first (0), header_second (1)
//
// One transaction is accepted per cycle while s_ready is high; each result passes
// from the middle stage into the result register, where m_valid rises.
// Receiver state and the frame store write update at the accept edge; the
// middle stage waits on the registered read port of the frame store.
// Reset is synchronous and active low; the frame store is not cleared.
// When both stages are full and the result is not taken, the middle stage holds
// and s_ready drops until the result is taken.

`include "header_length_sum_frame_receiver_assert.svh"

module header_length_sum_frame_receiver #(
    parameter int BUF_DEPTH = hlsfr_pkg::BUF_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hlsfr_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hlsfr_pkg::out_item_t m_item,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_index,
    input  logic [7:0]           cfg_wr_data
);

    localparam int ADDR_W = $clog2(BUF_DEPTH);
    localparam int POS_W  = hlsfr_pkg::POS_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUF_DEPTH - 1);
    localparam logic [POS_W:0]   DEPTH_EXT = (POS_W + 1)'(BUF_DEPTH);

    // Configuration registers.
    logic [7:0] header_first_reg;
    logic [7:0] header_second_reg;

    // Receiver state.
    logic [POS_W-1:0] wp_reg, wp_next;
    logic             synced_reg, synced_next;
    logic [7:0]       len_reg, len_next;
    logic             held_reg, held_next;
    logic [7:0]       held_cnt_reg, held_cnt_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       prev_reg, prev_next;
    logic [31:0]      fail_reg, fail_next;

    // Middle stage and result register.
    logic                 st1_valid_reg, st1_valid_next;
    hlsfr_pkg::out_item_t st1_item_reg, st1_item_next;
    logic                 st1_rd_sel_reg, st1_rd_sel_next;
    logic                 m_valid_reg, m_valid_next;
    hlsfr_pkg::out_item_t m_item_reg;

    logic             s_accept;
    logic             st1_adv;
    logic [POS_W-1:0] pos_inc;
    logic [2:0]       status;
    logic             ram_we;
    logic [7:0]       ram_rd_data;

    // Handshake: the middle stage moves on whenever the result register frees up.
    assign st1_adv  = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !st1_valid_reg || st1_adv;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign pos_inc  = wp_reg + POS_W'(1);

    // Frame store.
    hlsfr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg[ADDR_W-1:0]),
        .wr_data (s_item.data_byte),
        .rd_en   (s_accept),
        .rd_addr (s_item.read_index[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= hlsfr_pkg::HEADER_FIRST_RST;
            header_second_reg <= hlsfr_pkg::HEADER_SECOND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                hlsfr_pkg::CFG_HEADER_FIRST:  header_first_reg  <= cfg_wr_data;
                hlsfr_pkg::CFG_HEADER_SECOND: header_second_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Next receiver state and status for the accepted transaction.
    always_comb begin
        wp_next         = wp_reg;
        synced_next     = synced_reg;
        len_next        = len_reg;
        held_next       = held_reg;
        held_cnt_next   = held_cnt_reg;
        sum_next        = sum_reg;
        prev_next       = prev_reg;
        fail_next       = fail_reg;
        status          = hlsfr_pkg::ST_IGNORED;
        ram_we          = 1'b0;
        st1_rd_sel_next = 1'b0;
        if (s_accept) begin
            case (s_item.action)
                hlsfr_pkg::ACT_PUSH: begin
                    if (held_reg) begin
                        status = hlsfr_pkg::ST_IGNORED;
                    end else if (wp_reg >= LAST_POS) begin
                        wp_next = '0;
                        status  = hlsfr_pkg::ST_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        wp_next   = pos_inc;
                        status    = hlsfr_pkg::ST_STORED;
                        prev_next = s_item.data_byte;
                        if (wp_reg != '0) begin
                            if (!synced_reg) begin
                                // Hunt for the two header bytes as an aligned pair.
                                if (prev_reg == header_first_reg &&
                                    s_item.data_byte == header_second_reg) begin
                                    synced_next = 1'b1;
                                end else begin
                                    wp_next = '0;
                                end
                            end else if (pos_inc == POS_W'(3)) begin
                                // Length byte; it also opens the running sum.
                                len_next = s_item.data_byte;
                                sum_next = (s_item.data_byte >= 8'd3) ?
                                           {8'd0, s_item.data_byte} : 16'd0;
                            end else if ({1'b0, pos_inc} == {1'b0, len_reg} + 9'd2) begin
                                // Last byte: compare the big-endian check word.
                                if ({prev_reg, s_item.data_byte} == sum_reg) begin
                                    held_cnt_next = pos_inc;
                                    held_next     = 1'b1;
                                    status        = hlsfr_pkg::ST_GOOD;
                                end else begin
                                    fail_next = fail_reg + 32'd1;
                                    status    = hlsfr_pkg::ST_BAD;
                                end
                                wp_next     = '0;
                                synced_next = 1'b0;
                            end else if (wp_reg >= POS_W'(3) && wp_reg < len_reg) begin
                                sum_next = sum_reg + {8'd0, s_item.data_byte};
                            end
                        end
                    end
                end
                hlsfr_pkg::ACT_READ: begin
                    status          = hlsfr_pkg::ST_READ;
                    st1_rd_sel_next = ({1'b0, s_item.read_index} < DEPTH_EXT);
                end
                hlsfr_pkg::ACT_RELEASE: begin
                    held_next = 1'b0;
                    status    = hlsfr_pkg::ST_RELEASED;
                end
                default: begin
                    status = hlsfr_pkg::ST_IGNORED;
                end
            endcase
        end
        st1_item_next.status      = status;
        st1_item_next.read_data   = 8'd0;
        st1_item_next.held_length = held_cnt_next;
        st1_item_next.error_total = fail_next;
    end

    // Valid flags of the two result stages.
    always_comb begin
        st1_valid_next = st1_valid_reg;
        m_valid_next   = m_valid_reg;
        if (st1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_adv) begin
            st1_valid_next = 1'b0;
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            synced_reg    <= 1'b0;
            len_reg       <= 8'd0;
            held_reg      <= 1'b0;
            held_cnt_reg  <= 8'd0;
            sum_reg       <= 16'd0;
            prev_reg      <= 8'd0;
            fail_reg      <= 32'd0;
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            synced_reg    <= synced_next;
            len_reg       <= len_next;
            held_reg      <= held_next;
            held_cnt_reg  <= held_cnt_next;
            sum_reg       <= sum_next;
            prev_reg      <= prev_next;
            fail_reg      <= fail_next;
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers; read data joins on the way to the result register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_item_reg   <= st1_item_next;
            st1_rd_sel_reg <= st1_rd_sel_next;
        end
        if (st1_adv) begin
            m_item_reg <= {st1_item_reg.status,
                           (st1_rd_sel_reg ? ram_rd_data : 8'd0),
                           st1_item_reg.held_length,
                           st1_item_reg.error_total};
        end
    end

    // Checks on the receiver logic.
    `HLSFR_ASSERT_NEXT(a_held_push_ignored,
        s_accept && held_reg && s_item.action == hlsfr_pkg::ACT_PUSH,
        st1_item_reg.status == hlsfr_pkg::ST_IGNORED,
        "push while a frame is held was not ignored")
    `HLSFR_ASSERT_SAME(a_pos_in_range, 1'b1, wp_reg <= LAST_POS,
        "write position beyond the frame store")
    `HLSFR_ASSERT_NEXT(a_fail_count_step, 1'b1,
        fail_reg == $past(fail_reg) ||
        (fail_reg == $past(fail_reg) + 32'd1 && st1_item_reg.status == hlsfr_pkg::ST_BAD),
        "error counter moved without a checksum failure")
    `HLSFR_ASSERT_SAME(a_held_not_synced, held_reg, !synced_reg,
        "receiver synchronized while a frame is held")
    `HLSFR_ASSERT_SAME(a_stall_cause, !s_ready,
        st1_valid_reg && m_valid_reg && !m_ready,
        "input stalled without a full, blocked result path")

endmodule
